@@ design/ppd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants of the path point densifier.
// Holds the job descriptor passed from the front end to the back end.
// ----------------------------------------------------------------------------
package ppd_pkg;

	localparam int IO_W = 17;

	// Front-end sequencer states.
	typedef enum logic [1:0] {
		FE_IDLE,
		FE_SQRT,
		FE_DIV,
		FE_PUSH
	} fe_state_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BE_IDLE,
		BE_LOAD,
		BE_DIV,
		BE_MID,
		BE_KEY
	} be_state_t;

	// One job handed to the back end: new key point, midpoint count, clip flag.
	typedef struct packed {
		logic signed [IO_W-1:0] kx;
		logic signed [IO_W-1:0] ky;
		logic signed [IO_W-1:0] kh;
		logic signed [IO_W-1:0] ka;
		logic [5:0]             n;
		logic                   clip;
	} job_t;

endpackage

@@ design/ppd_front.sv @@
// ----------------------------------------------------------------------------
// ppd_front: accepts key points, finds the distance by a bit-serial square
// root and the midpoint count by a restoring divider, then queues a job.
// ----------------------------------------------------------------------------
module ppd_front #(
	parameter int MAX_MIDPOINTS = 63,
	parameter int COORD_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [15:0]                  min_spacing,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [16:0]           key_x,
	input  logic signed [16:0]           key_y,
	input  logic signed [16:0]           key_heading,
	input  logic signed [16:0]           key_accel,
	input  logic                         path_start,
	output logic                         job_valid,
	input  logic                         job_stall,
	output ppd_pkg::job_t                job,
	output logic signed [COORD_BITS-1:0] prev_x,
	output logic signed [COORD_BITS-1:0] prev_y,
	output logic signed [COORD_BITS-1:0] prev_h,
	output logic signed [COORD_BITS-1:0] prev_a
);
	import ppd_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;
	localparam int SQW = 2 * DW + 2;
	localparam int RW = DW + 1;
	localparam int CNT_W = $clog2(RW + 1);

	fe_state_t state_q, state_d;
	logic signed [CW-1:0] kx_q, ky_q, kh_q, ka_q;
	logic start_q, have_prev_q;
	logic [SQW-1:0] rem_q;
	logic [SQW-1:0] root_q;
	logic [SQW-1:0] bit_q;
	logic [RW-1:0]  dq_q;
	logic [RW-1:0]  dr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [5:0] n_q;
	logic clip_q;
	logic [15:0] sp;
	logic signed [CW-1:0] wx, wy, wh, wa;
	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] ux, uy;
	logic [2*DW-1:0] sq_x, sq_y;
	logic [RW:0] trial;
	logic [SQW-1:0] sq_sum;
	logic [RW-1:0] root_len;

	assign sp = (min_spacing == 16'd0) ? 16'd1 : min_spacing;
	assign wx = CW'(key_x);
	assign wy = CW'(key_y);
	assign wh = CW'(key_heading);
	assign wa = CW'(key_accel);
	assign dx = DW'(kx_q) - DW'(prev_x);
	assign dy = DW'(ky_q) - DW'(prev_y);
	assign ux = dx[DW-1] ? DW'(-dx) : dx;
	assign uy = dy[DW-1] ? DW'(-dy) : dy;
	assign sq_x = ux * ux;
	assign sq_y = uy * uy;
	assign sq_sum = root_q + bit_q;
	assign root_len = RW'(root_q);
	assign trial = {dr_q, dq_q[RW-1]} - (RW+1)'(sp);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FE_IDLE: if (in_valid) state_d = FE_SQRT;
			FE_SQRT: begin
				// The load cycle is the only one with a zero count.
				if (start_q || !have_prev_q) state_d = FE_PUSH;
				else if (bit_q == '0 && cnt_q != '0) state_d = FE_DIV;
			end
			FE_DIV:  if (cnt_q == '0) state_d = FE_PUSH;
			FE_PUSH: if (!job_stall) state_d = FE_IDLE;
			default: state_d = FE_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != FE_IDLE);
		job_valid = (state_q == FE_PUSH);
		job.kx = IO_W'(kx_q);
		job.ky = IO_W'(ky_q);
		job.kh = IO_W'(kh_q);
		job.ka = IO_W'(ka_q);
		job.n = n_q;
		job.clip = clip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			have_prev_q <= 1'b0;
			prev_x <= '0; prev_y <= '0; prev_h <= '0; prev_a <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FE_PUSH && !job_stall) begin
				have_prev_q <= 1'b1;
				prev_x <= kx_q; prev_y <= ky_q; prev_h <= kh_q; prev_a <= ka_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FE_IDLE: begin
				kx_q <= wx; ky_q <= wy; kh_q <= wh; ka_q <= wa;
				start_q <= path_start;
				n_q <= '0;
				clip_q <= 1'b0;
				rem_q <= '0;
				root_q <= '0;
				bit_q <= '0;
				cnt_q <= '0;
			end
			FE_SQRT: begin
				if (bit_q == '0 && rem_q == '0 && root_q == '0 && cnt_q == '0) begin
					// First cycle: load the squared distance.
					rem_q <= SQW'(sq_x) + SQW'(sq_y);
					bit_q <= SQW'(1) << (SQW - 2);
					cnt_q <= CNT_W'(1);
				end else if (bit_q != '0) begin
					if (rem_q >= sq_sum) begin
						rem_q <= rem_q - sq_sum;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					dq_q <= root_len;
					dr_q <= '0;
					cnt_q <= CNT_W'(RW);
				end
			end
			FE_DIV: begin
				if (cnt_q != '0) begin
					if (!trial[RW]) begin
						dr_q <= trial[RW-1:0];
						dq_q <= {dq_q[RW-2:0], 1'b1};
					end else begin
						dr_q <= {dr_q[RW-2:0], dq_q[RW-1]};
						dq_q <= {dq_q[RW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CNT_W'(1);
				end
				if (cnt_q == '0) begin
					if (root_len > RW'(sp)) begin
						if (dq_q - RW'(1) > RW'(MAX_MIDPOINTS)) begin
							n_q <= 6'(MAX_MIDPOINTS);
							clip_q <= 1'b1;
						end else begin
							n_q <= 6'(dq_q - RW'(1));
						end
					end
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> job.n <= 6'(MAX_MIDPOINTS))
		else $error("count above limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		job.clip && job_valid |-> job.n == 6'(MAX_MIDPOINTS))
		else $error("clip without saturation");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> in_stall)
		else $error("accept while job pending");
endmodule

@@ design/ppd_back.sv @@
// ----------------------------------------------------------------------------
// ppd_back: emits the midpoints of one job and then the key point. Each
// midpoint is computed by a shared rounding divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ppd_back #(
	parameter int COORD_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	output logic                         job_stall,
	input  ppd_pkg::job_t                job,
	input  logic signed [COORD_BITS-1:0] prev_x,
	input  logic signed [COORD_BITS-1:0] prev_y,
	input  logic signed [COORD_BITS-1:0] prev_h,
	input  logic signed [COORD_BITS-1:0] prev_a,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [16:0]           point_x,
	output logic signed [16:0]           point_y,
	output logic signed [16:0]           point_heading,
	output logic signed [16:0]           point_accel,
	output logic                         is_key,
	output logic                         run_last,
	output logic                         clipped
);
	import ppd_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;
	localparam int NW = DW + 8;    // |2*k*diff + d| fits
	localparam int CNT_W = $clog2(NW + 1);

	be_state_t state_q, state_d;
	job_t job_q;
	logic signed [CW-1:0] px_q, py_q, ph_q, pa_q;
	logic [5:0] k_q;
	logic [1:0] lane_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0] num_q, q_q;
	logic [7:0] rem_q;
	logic neg_q;
	logic signed [CW-1:0] res_q [4];
	logic out_free, emit_mid, emit_key;
	logic [6:0] d;
	logic [7:0] den;
	logic [8:0] trial;
	logic signed [DW-1:0] diff;
	logic signed [CW-1:0] base;
	logic signed [NW-1:0] prod;
	logic signed [NW-1:0] num_s;
	logic [NW-1:0] num_mag;
	logic [NW-1:0] q_fin;
	logic signed [CW-1:0] lane_res;

	// The divisor is 2*(n+1); the added half of it rounds halves upward.
	assign d = {1'b0, job_q.n} + 7'd1;
	assign den = {d, 1'b0};
	assign trial = {rem_q, num_q[NW-1]} - {1'b0, den};
	assign prod = NW'(diff) * NW'($signed({1'b0, k_q}));
	assign num_s = {prod[NW-2:0], 1'b0} + NW'(d);
	assign num_mag = num_s[NW-1] ? NW'(-num_s) : num_s;
	// Floor division of a negative numerator: negate and round the magnitude up.
	assign q_fin = neg_q ? NW'(-(q_q + NW'(rem_q != 8'd0))) : q_q;
	assign lane_res = base + CW'(q_fin);

	always_comb begin
		case (lane_q)
			2'd0: begin
				diff = DW'(CW'(job_q.kx)) - DW'(px_q);
				base = px_q;
			end
			2'd1: begin
				diff = DW'(CW'(job_q.ky)) - DW'(py_q);
				base = py_q;
			end
			2'd2: begin
				diff = DW'(CW'(job_q.kh)) - DW'(ph_q);
				base = ph_q;
			end
			default: begin
				diff = DW'(CW'(job_q.ka)) - DW'(pa_q);
				base = pa_q;
			end
		endcase
	end

	always_comb begin
		job_stall = (state_q != BE_IDLE);
		out_free = !out_valid || !out_stall;
		emit_mid = (state_q == BE_MID) && out_free;
		emit_key = (state_q == BE_KEY) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BE_IDLE: begin
				if (job_valid) state_d = (job.n != 6'd0) ? BE_LOAD : BE_KEY;
			end
			BE_LOAD: state_d = BE_DIV;
			BE_DIV: begin
				if (cnt_q == '0) state_d = (lane_q == 2'd3) ? BE_MID : BE_LOAD;
			end
			BE_MID: begin
				if (out_free) state_d = (k_q == job_q.n) ? BE_KEY : BE_LOAD;
			end
			BE_KEY: begin
				if (out_free) state_d = BE_IDLE;
			end
			default: state_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_mid || emit_key) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BE_IDLE: begin
				if (job_valid) begin
					job_q <= job;
					px_q <= prev_x; py_q <= prev_y; ph_q <= prev_h; pa_q <= prev_a;
					k_q <= 6'd1;
					lane_q <= 2'd0;
				end
			end
			BE_LOAD: begin
				num_q <= num_mag;
				neg_q <= num_s[NW-1];
				q_q <= '0;
				rem_q <= '0;
				cnt_q <= CNT_W'(NW);
			end
			BE_DIV: begin
				if (cnt_q != '0) begin
					if (!trial[8]) begin
						rem_q <= trial[7:0];
						q_q <= {q_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[6:0], num_q[NW-1]};
						q_q <= {q_q[NW-2:0], 1'b0};
					end
					num_q <= {num_q[NW-2:0], 1'b0};
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					res_q[lane_q] <= lane_res;
					lane_q <= lane_q + 2'd1;
				end
			end
			BE_MID: begin
				if (emit_mid) begin
					point_x <= IO_W'(res_q[0]); point_y <= IO_W'(res_q[1]);
					point_heading <= IO_W'(res_q[2]);
					point_accel <= IO_W'(res_q[3]);
					is_key <= 1'b0; run_last <= 1'b0; clipped <= job_q.clip;
					k_q <= k_q + 6'd1;
				end
			end
			BE_KEY: begin
				if (emit_key) begin
					point_x <= job_q.kx; point_y <= job_q.ky;
					point_heading <= job_q.kh; point_accel <= job_q.ka;
					is_key <= 1'b1; run_last <= 1'b1; clipped <= job_q.clip;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_last |-> is_key)
		else $error("last beat is not the key point");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(is_key) && $stable(run_last))
		else $error("stalled beat changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_stall |=> state_q != BE_IDLE)
		else $error("job lost");
endmodule

@@ design/path_point_densifier.sv @@
// ----------------------------------------------------------------------------
// path_point_densifier: top level.
// Densifies a path given by key points with evenly spaced midpoints.
// ----------------------------------------------------------------------------
// Key points are taken one at a time. For a key point that follows another
// point of the same path the front end goes through an accept state, a load
// step, a bit-serial square root of the squared x-y distance, a step that
// starts the divide, a restoring divide by the spacing register and a
// hand-over state. A path start or the first key point after reset skips the
// root and the divide. For each midpoint the back end uses one shared divider
// that rounds k*diff/(n+1) for the four coordinates in turn (a load state,
// a COORD_BITS+9 bit quotient and a store step each), followed by the
// midpoint beat; the key point beat comes last. Output stalls hold the back
// end on the pending beat. The front end holds a finished job until the back
// end is idle, so it can work on the next key point while the back end is
// still emitting beats for the previous one.
module path_point_densifier #(
	parameter int MAX_MIDPOINTS = 63,
	parameter int COORD_BITS = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [16:0]    key_x,
	input  logic signed [16:0]    key_y,
	input  logic signed [16:0]    key_heading,
	input  logic signed [16:0]    key_accel,
	input  logic                  path_start,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [16:0]    point_x,
	output logic signed [16:0]    point_y,
	output logic signed [16:0]    point_heading,
	output logic signed [16:0]    point_accel,
	output logic                  is_key,
	output logic                  run_last,
	output logic                  clipped
);
	import ppd_pkg::*;

	logic [15:0] min_spacing_q;
	logic job_valid, job_stall;
	job_t job;
	logic signed [COORD_BITS-1:0] prev_x, prev_y, prev_h, prev_a;

	// The spacing register resets to one half in Q8.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_spacing_q <= 16'd128;
		else if (cfg_we) min_spacing_q <= cfg_wdata;
	end

	ppd_front #(.MAX_MIDPOINTS(MAX_MIDPOINTS), .COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .min_spacing(min_spacing_q), .in_valid, .in_stall,
		.key_x, .key_y, .key_heading, .key_accel, .path_start,
		.job_valid, .job_stall, .job, .prev_x, .prev_y, .prev_h, .prev_a
	);

	ppd_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .job_valid, .job_stall, .job,
		.prev_x, .prev_y, .prev_h, .prev_a,
		.out_valid, .out_stall, .point_x, .point_y, .point_heading, .point_accel,
		.is_key, .run_last, .clipped
	);
endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the path point densifier.
// Key points are fed through the valid/stall input channel, and every
// accepted beat is run through a local predictor that works out the densified
// points. The monitor compares each output beat field by field with the
// oldest predicted point. The spacing register is changed between phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppd_pkg::*;

	localparam int MAX_MID = 63;
	localparam int SHOW_LIMIT = 10;

	// One key point as the sender presents it.
	typedef struct {
		logic signed [IO_W-1:0] x;
		logic signed [IO_W-1:0] y;
		logic signed [IO_W-1:0] h;
		logic signed [IO_W-1:0] a;
		logic                   start;
	} key_pt_t;

	// One densified output point.
	typedef struct {
		logic [IO_W-1:0] x;
		logic [IO_W-1:0] y;
		logic [IO_W-1:0] h;
		logic [IO_W-1:0] a;
		logic            key;
		logic            last;
		logic            clip;
	} dense_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [16:0] key_x = '0;
	logic signed [16:0] key_y = '0;
	logic signed [16:0] key_heading = '0;
	logic signed [16:0] key_accel = '0;
	logic path_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [16:0] point_x;
	logic signed [16:0] point_y;
	logic signed [16:0] point_heading;
	logic signed [16:0] point_accel;
	logic is_key;
	logic run_last;
	logic clipped;

	path_point_densifier u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_x(key_x),
		.key_y(key_y),
		.key_heading(key_heading),
		.key_accel(key_accel),
		.path_start(path_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_x(point_x),
		.point_y(point_y),
		.point_heading(point_heading),
		.point_accel(point_accel),
		.is_key(is_key),
		.run_last(run_last),
		.clipped(clipped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	key_pt_t   key_queue[$];
	dense_pt_t dense_expected[$];
	int        mismatches = 0;

	// Percent of cycles in which the sender idles or the receiver stalls.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Predictor state: spacing register and the previous key point.
	logic [15:0] spacing_reg = 16'd128;
	longint      last_x, last_y, last_h, last_a;
	bit          have_last = 1'b0;

	// Tracks where the stimulus generator believes the path currently is.
	int gen_x = 0;
	int gen_y = 0;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// k*diff/d rounded to nearest, halves toward plus infinity.
	function automatic longint lerp_offset(longint diff, longint k, longint d);
		longint num = 2 * k * diff + d;
		longint den = 2 * d;
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	// Works out every point that one accepted key point produces and queues them.
	function automatic void densify_key(key_pt_t kp);
		longint kx = kp.x;
		longint ky = kp.y;
		longint kh = kp.h;
		longint ka = kp.a;
		longint dx, dy, dh, da;
		longint unsigned seg_len, sp, n;
		bit clip = 1'b0;
		dense_pt_t pt;
		n = 0;
		if (!kp.start && have_last) begin
			dx = kx - last_x;
			dy = ky - last_y;
			dh = kh - last_h;
			da = ka - last_a;
			seg_len = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
			sp = (spacing_reg == 0) ? 1 : spacing_reg;
			if (seg_len > sp) begin
				n = seg_len / sp - 1;
				if (n > MAX_MID) begin
					n = MAX_MID;
					clip = 1'b1;
				end
			end
			for (longint k = 1; k <= longint'(n); k++) begin
				pt.x = IO_W'(last_x + lerp_offset(dx, k, n + 1));
				pt.y = IO_W'(last_y + lerp_offset(dy, k, n + 1));
				pt.h = IO_W'(last_h + lerp_offset(dh, k, n + 1));
				pt.a = IO_W'(last_a + lerp_offset(da, k, n + 1));
				pt.key = 1'b0;
				pt.last = 1'b0;
				pt.clip = clip;
				dense_expected = {dense_expected, pt};
			end
		end
		pt.x = kp.x;
		pt.y = kp.y;
		pt.h = kp.h;
		pt.a = kp.a;
		pt.key = 1'b1;
		pt.last = 1'b1;
		pt.clip = clip;
		dense_expected = {dense_expected, pt};
		last_x = kx;
		last_y = ky;
		last_h = kh;
		last_a = ka;
		have_last = 1'b1;
	endfunction

	// Driver: holds a stalled beat, otherwise may present the next key point.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				densify_key('{key_x, key_y, key_heading, key_accel, path_start});
			if (!(in_valid && in_stall)) begin
				if (key_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					key_pt_t kp;
					kp = key_queue.pop_front();
					key_x <= kp.x;
					key_y <= kp.y;
					key_heading <= kp.h;
					key_accel <= kp.a;
					path_start <= kp.start;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random stall on the output side and the field-by-field check.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (dense_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("unexpected output beat x=%0d y=%0d", point_x, point_y);
				end else begin
					dense_pt_t e;
					e = dense_expected.pop_front();
					if (e.x !== point_x || e.y !== point_y || e.h !== point_heading ||
						e.a !== point_accel || e.key !== is_key ||
						e.last !== run_last || e.clip !== clipped) begin
						mismatches++;
						if (mismatches <= SHOW_LIMIT) begin
							$display("mismatch: expected x=%0d y=%0d h=%0d a=%0d key=%b last=%b clip=%b",
								$signed(e.x), $signed(e.y), $signed(e.h), $signed(e.a),
								e.key, e.last, e.clip);
							$display("          got x=%0d y=%0d h=%0d a=%0d key=%b last=%b clip=%b",
								point_x, point_y, point_heading, point_accel,
								is_key, run_last, clipped);
						end
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic add_key(int x, int y, int h, int a, bit s);
		key_queue = {key_queue, key_pt_t'{IO_W'(x), IO_W'(y), IO_W'(h), IO_W'(a), s}};
		gen_x = x;
		gen_y = y;
	endtask

	function automatic int clamp_coord(int v);
		if (v > 65535)
			return 65535;
		if (v < -65536)
			return -65536;
		return v;
	endfunction

	// Random walk: moves of up to eight spacings per axis, with occasional path
	// starts, jumps anywhere (wild_pct percent, which tend to clip) and repeated points.
	task automatic add_walk(int count, int sp, int wild_pct);
		int step, nx, ny, sel;
		bit s;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			s = ($urandom_range(99) < 10);
			if (sel < wild_pct) begin
				nx = $signed(17'($urandom));
				ny = $signed(17'($urandom));
			end else if (sel < wild_pct + 5) begin
				nx = gen_x;
				ny = gen_y;
			end else begin
				step = sp * $urandom_range(8);
				nx = clamp_coord(gen_x + $urandom_range(2 * step) - step);
				ny = clamp_coord(gen_y + $urandom_range(2 * step) - step);
			end
			add_key(nx, ny, $signed(17'($urandom)), $signed(17'($urandom)), s);
		end
	endtask

	// Waits until everything sent has come back out, plus a margin.
	task automatic drain();
		while (key_queue.size() != 0 || in_valid || dense_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_spacing(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		spacing_reg = v;
	endtask

	task automatic set_pacing(int idle_pct, int stall_pct);
		@(posedge clk);
		send_idle_pct <= idle_pct;
		recv_stall_pct <= stall_pct;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset spacing of 0.5: no previous point, huge
		// jumps that clip, a path restart, zero distance, distance equal to
		// the spacing, below twice the spacing, and a few ordinary runs.
		add_key(0, 0, 0, 0, 1'b0);
		add_key(-65536, -65536, -65536, -65536, 1'b0);
		add_key(65535, 65535, 65535, 65535, 1'b0);
		add_key(65535, 65535, -65536, 65535, 1'b1);
		add_key(65535, 65535, 65535, -65536, 1'b0);
		add_key(65535 - 128, 65535, -1, 1, 1'b0);
		add_key(65535 - 383, 65535, 65535, -65536, 1'b0);
		add_key(65535 - 639, 65535, -65536, 65535, 1'b0);
		add_key(65535 - 1919, 65535 - 3, 1000, -1000, 1'b0);
		add_key(65535 - 1619, 65535 - 403, -7, 5, 1'b0);
		add_key(-300, 200, 43690, -43691, 1'b1);
		add_key(-300, -1000, -43691, 43690, 1'b0);
		add_key(-299, -1001, 21845, -21846, 1'b0);
		drain();

		// Spacing zero behaves as the smallest spacing; short moves only.
		write_spacing(16'd0);
		set_pacing(36, 36);
		add_key(100, 100, 5, 5, 1'b1);
		add_key(90, 107, -5, 9, 1'b0);
		add_key(200, 80, 65535, -65536, 1'b0);
		drain();

		write_spacing(16'd1);
		add_key(0, 0, 0, 0, 1'b0);
		add_key(-20, 15, 100, -100, 1'b0);
		add_key(-20, 15, 1, 1, 1'b0);
		drain();

		// Largest spacing: even a jump across the whole coordinate range yields at most one midpoint.
		write_spacing(16'hFFFF);
		set_pacing(0, 0);
		add_walk(20, 30000, 60);
		drain();

		write_spacing(16'd256);
		set_pacing(47, 0);
		add_walk(90, 256, 3);
		drain();

		write_spacing(16'd700);
		set_pacing(0, 47);
		add_walk(90, 700, 3);
		drain();

		write_spacing(16'd1024);
		set_pacing(36, 36);
		add_walk(80, 1024, 3);
		drain();

		set_pacing(0, 0);
		add_walk(20, 1024, 3);
		drain();
		repeat (200) @(posedge clk);

		if (mismatches == 0 && dense_expected.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Watchdog well above the slowest legal run.
	initial begin
		#200ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule
